@@ hdl/uepd_pkg.sv @@
package uepd_pkg;

	typedef enum logic [3:0] {
		OP_SIZE      = 4'd0,
		OP_RX_PUSH   = 4'd1,
		OP_RX_POP    = 4'd2,
		OP_RX_DEQ    = 4'd3,
		OP_RX_DEQALL = 4'd4,
		OP_TX_PUSH   = 4'd5,
		OP_SET_TOG   = 4'd6,
		OP_RST_BANK  = 4'd7,
		OP_RST_DATA  = 4'd8,
		OP_RETURNED  = 4'd9
	} opcode_t;

	localparam int OWN_BIT    = 7;
	localparam int DATA01_BIT = 6;
	localparam int DTS_BIT    = 3;
	localparam int BC_WIDTH   = 10;

	typedef struct packed {
		logic [3:0]  opcode;
		logic [3:0]  endpoint;
		logic        direction;
		logic        bank_select;
		logic        toggle_value;
		logic [9:0]  length_value;
		logic [31:0] buffer_address;
		logic        buffer_given;
	} item_t;

	typedef struct packed {
		logic        ok;
		logic        descriptor_write;
		logic [5:0]  descriptor_index;
		logic [31:0] descriptor_word;
		logic [31:0] address_out;
		logic        use_default_buffer;
		logic [7:0]  armed_bytes;
		logic        data_toggle_now;
		logic        bank_toggle_now;
		logic        last;
	} result_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SECOND,
		ST_OUT
	} state_t;

	// Controller to datapath.
	typedef struct packed {
		logic load;
		logic exec;
		logic second;
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic need_second;
	} sts_t;

endpackage

@@ hdl/uepd_if.sv @@
interface uepd_item_if import uepd_pkg::*; ();
	logic  valid;
	logic  ready;
	item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface uepd_result_if import uepd_pkg::*; ();
	logic    valid;
	logic    ready;
	result_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ hdl/uepd_ctrl.sv @@
module uepd_ctrl import uepd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// The datapath holds need_second from the execute step until the second
	// result has been produced.
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_valid) state_next = ST_EXEC;
			ST_EXEC:   state_next = ST_OUT;
			ST_SECOND: state_next = ST_OUT;
			ST_OUT: begin
				if (out_ready) state_next = sts.need_second ? ST_SECOND : ST_IDLE;
			end
			default:   state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready   = 1'b0;
		out_valid  = 1'b0;
		cmd        = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_EXEC:   cmd.exec = 1'b1;
			ST_SECOND: cmd.second = 1'b1;
			ST_OUT:    out_valid = 1'b1;
			default:   ;
		endcase
	end

endmodule

@@ hdl/uepd_datapath.sv @@
module uepd_datapath import uepd_pkg::*; #(
	parameter int ENDPOINT_COUNT   = 16,
	parameter int BYTE_COUNT_SHIFT = 16
) (
	input  logic    clk,
	input  logic    arst_n,
	input  item_t   item,
	input  cmd_t    cmd,
	output sts_t    sts,
	output result_t result
);

	item_t       it_q;
	logic [7:0]  size_q  [16];
	logic [1:0]  cnt_q   [16];
	logic [31:0] bank_q;
	logic [31:0] data_q;
	logic [63:0] own_q;
	result_t     res_q;
	logic        need_q;
	result_t     res_d;
	logic        need_d;

	logic [3:0]  ep;
	logic        valid_ep;
	logic        op_known;
	logic [4:0]  rxs, txs, ds;
	logic [1:0]  cnt;
	logic [7:0]  sz;
	logic        rx_bank, tx_bank;
	logic [5:0]  rx_idx, tx_idx;
	logic [7:0]  len_sat, rx_psz, tx_psz;
	logic [5:0]  deq_idx;
	logic [5:0]  ret_idx;

	function automatic logic [31:0] make_word(input logic [7:0] psz, input logic tog);
		logic [31:0] w;
		w = '0;
		w[OWN_BIT]    = 1'b1;
		w[DTS_BIT]    = 1'b1;
		w[DATA01_BIT] = tog;
		w = w | (32'({2'b00, psz}) << BYTE_COUNT_SHIFT);
		return w;
	endfunction

	assign ep       = it_q.endpoint;
	assign valid_ep = 32'(ep) < ENDPOINT_COUNT;
	assign op_known = it_q.opcode <= OP_RETURNED;
	assign rxs      = {ep, 1'b0};
	assign txs      = {ep, 1'b1};
	assign ds       = {ep, it_q.direction};
	assign cnt      = cnt_q[ep];
	assign sz       = size_q[ep];
	assign rx_bank  = bank_q[rxs] ^ cnt[0];
	assign tx_bank  = bank_q[txs];
	assign rx_idx   = {ep, 1'b0, rx_bank};
	assign tx_idx   = {ep, 1'b1, tx_bank};
	assign len_sat  = (it_q.length_value > 10'd255) ? 8'd255 : it_q.length_value[7:0];
	assign rx_psz   = (it_q.buffer_given && (len_sat < sz)) ? len_sat : sz;
	assign tx_psz   = (len_sat < sz) ? len_sat : sz;
	// Dequeue removes the newest bank: active bank plus count minus one.
	assign deq_idx  = {ep, 1'b0, bank_q[rxs] ^ (cnt[0] ^ 1'b1)};
	assign ret_idx  = {ep, it_q.direction, it_q.bank_select};
	assign sts.need_second = need_q;
	assign result   = res_q;

	always_ff @(posedge clk) begin
		if (cmd.load) it_q <= item;
	end

	// Result of the current step, from the state before it.
	always_comb begin
		res_d      = '0;
		res_d.last = 1'b1;
		need_d     = 1'b0;
		if (cmd.second) begin
			// Second bank of dequeue-all; count is now one.
			res_d.ok               = 1'b1;
			res_d.descriptor_write = 1'b1;
			res_d.descriptor_index = deq_idx;
			res_d.data_toggle_now  = data_q[rxs];
			res_d.bank_toggle_now  = bank_q[rxs];
		end else if (it_q.opcode == OP_RST_BANK || it_q.opcode == OP_RST_DATA) begin
			res_d.ok = 1'b1;
			if (it_q.opcode == OP_RST_BANK) begin
				res_d.data_toggle_now = valid_ep & data_q[ds];
			end else begin
				res_d.bank_toggle_now = valid_ep & bank_q[ds];
			end
		end else if (valid_ep && op_known) begin
			res_d.ok = 1'b1;
			res_d.data_toggle_now = data_q[ds];
			res_d.bank_toggle_now = bank_q[ds];
			case (opcode_t'(it_q.opcode))
				OP_RX_PUSH: begin
					res_d.data_toggle_now = data_q[rxs];
					res_d.bank_toggle_now = bank_q[rxs];
					if (cnt >= 2'd2) begin
						res_d.ok = 1'b0;
					end else begin
						res_d.data_toggle_now    = ~data_q[rxs];
						res_d.descriptor_write   = 1'b1;
						res_d.descriptor_index   = rx_idx;
						res_d.descriptor_word    = make_word(rx_psz, data_q[rxs]);
						res_d.address_out        = it_q.buffer_given ?
							it_q.buffer_address : '0;
						res_d.use_default_buffer = ~it_q.buffer_given;
						res_d.armed_bytes        = rx_psz;
					end
				end
				OP_RX_POP: begin
					res_d.data_toggle_now = data_q[rxs];
					res_d.bank_toggle_now = bank_q[rxs];
					if (cnt == 2'd0) begin
						res_d.ok = 1'b0;
					end else begin
						res_d.bank_toggle_now = ~bank_q[rxs];
					end
				end
				OP_RX_DEQ, OP_RX_DEQALL: begin
					res_d.data_toggle_now = data_q[rxs];
					res_d.bank_toggle_now = bank_q[rxs];
					if (cnt == 2'd0) begin
						res_d.ok = (it_q.opcode == OP_RX_DEQALL);
					end else begin
						res_d.descriptor_write = 1'b1;
						res_d.descriptor_index = deq_idx;
						if (it_q.opcode == OP_RX_DEQALL && cnt > 2'd1) begin
							res_d.last = 1'b0;
							need_d     = 1'b1;
						end
					end
				end
				OP_TX_PUSH: begin
					res_d.data_toggle_now = data_q[txs];
					res_d.bank_toggle_now = bank_q[txs];
					if (own_q[tx_idx]) begin
						res_d.ok = 1'b0;
					end else begin
						res_d.data_toggle_now  = ~data_q[txs];
						res_d.bank_toggle_now  = ~tx_bank;
						res_d.descriptor_write = 1'b1;
						res_d.descriptor_index = tx_idx;
						res_d.descriptor_word  = make_word(tx_psz, data_q[txs]);
						res_d.address_out      = it_q.buffer_address;
						res_d.armed_bytes      = tx_psz;
					end
				end
				OP_SET_TOG: res_d.data_toggle_now = it_q.toggle_value;
				default: ;
			endcase
		end else begin
			res_d.ok = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) begin
				size_q[i] <= '0;
				cnt_q[i]  <= '0;
			end
			bank_q <= '0;
			data_q <= '0;
			own_q  <= '0;
			need_q <= 1'b0;
			res_q  <= '0;
		end else begin
			if (cmd.exec || cmd.second) begin
				res_q  <= res_d;
				need_q <= need_d;
			end
			if (cmd.exec) begin
				if (it_q.opcode == OP_RST_BANK) begin
					bank_q <= '0;
				end else if (it_q.opcode == OP_RST_DATA) begin
					data_q <= '0;
				end else if (valid_ep && op_known) begin
					case (opcode_t'(it_q.opcode))
						OP_SIZE: size_q[ep] <= len_sat;
						OP_RX_PUSH: begin
							if (cnt < 2'd2) begin
								cnt_q[ep]     <= cnt + 2'd1;
								data_q[rxs]   <= ~data_q[rxs];
								own_q[rx_idx] <= 1'b1;
							end
						end
						OP_RX_POP: begin
							if (cnt != 2'd0) begin
								bank_q[rxs] <= ~bank_q[rxs];
								cnt_q[ep]   <= cnt - 2'd1;
							end
						end
						OP_RX_DEQ, OP_RX_DEQALL: begin
							if (cnt != 2'd0) begin
								cnt_q[ep]      <= cnt - 2'd1;
								own_q[deq_idx] <= 1'b0;
							end
						end
						OP_TX_PUSH: begin
							if (!own_q[tx_idx]) begin
								data_q[txs]   <= ~data_q[txs];
								bank_q[txs]   <= ~tx_bank;
								own_q[tx_idx] <= 1'b1;
							end
						end
						OP_SET_TOG: data_q[ds] <= it_q.toggle_value;
						OP_RETURNED: own_q[ret_idx] <= 1'b0;
						default: ;
					endcase
				end
			end else if (cmd.second) begin
				cnt_q[ep]      <= cnt - 2'd1;
				own_q[deq_idx] <= 1'b0;
			end
		end
	end

endmodule

@@ hdl/usb_endpoint_pingpong_descriptor_manager.sv @@
// USB endpoint ping-pong buffer descriptor manager.
// Commands arrive on the cmd_in channel (valid/ready); each transaction
// carries an opcode, an endpoint number and operands. Results leave on the
// res_out channel, one transaction per result; the field last marks the
// final result of a command. Dequeue-all with two banks queued gives two.
// A command is captured at the accepting edge, then executed against the
// endpoint state into the result register, which presents it on res_out.
// The controller runs capture, execute, present for every command; the
// second result of a dequeue-all adds a further execute and present.
// The block takes one command at a time; cmd_in.ready is low from the
// accepting edge until the last result of that command has been taken.
// When the receiver stalls, the result register holds its value and no
// new command is accepted.
// Reset (arst_n low) clears all endpoint sizes, queue counts, bank and
// data toggles and ownership marks at once; the block is ready as soon as
// reset is released.
module usb_endpoint_pingpong_descriptor_manager import uepd_pkg::*; #(
	parameter int ENDPOINT_COUNT   = 16,
	parameter int BYTE_COUNT_SHIFT = 16
) (
	input logic         clk,
	input logic         arst_n,
	uepd_item_if.sink   cmd_in,
	uepd_result_if.source res_out
);

	cmd_t cmd;
	sts_t sts;

	uepd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cmd_in.valid),
		.in_ready  (cmd_in.ready),
		.out_valid (res_out.valid),
		.out_ready (res_out.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	uepd_datapath #(
		.ENDPOINT_COUNT   (ENDPOINT_COUNT),
		.BYTE_COUNT_SHIFT (BYTE_COUNT_SHIFT)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (cmd_in.data),
		.cmd    (cmd),
		.sts    (sts),
		.result (res_out.data)
	);

endmodule

@@ hdl/uepd_checker.sv @@
module uepd_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic out_last,
	input logic out_write,
	input logic [7:0] out_psz
);

	// No command is taken while a result waits.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("command accepted while result pending");

	// An accepted command leads to a result after the capture and execute steps.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |-> ##2 out_valid)
		else $error("result missing after command");

	// A non-final result is followed by another one.
	a_follow: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !out_last) |=> !in_ready)
		else $error("second result missing");

	// A packet size is only reported with a descriptor write.
	a_psz: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_psz != 8'd0) |-> out_write)
		else $error("packet size without write");

endmodule

bind usb_endpoint_pingpong_descriptor_manager uepd_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (cmd_in.valid),
	.in_ready  (cmd_in.ready),
	.out_valid (res_out.valid),
	.out_ready (res_out.ready),
	.out_last  (res_out.data.last),
	.out_write (res_out.data.descriptor_write),
	.out_psz   (res_out.data.armed_bytes)
);

@@ tb/descriptor_checker.sv @@
`timescale 1ns / 100ps

module descriptor_checker import uepd_pkg::*; (
	input logic clk,
	input logic arst_n,
	uepd_item_if.sink cmd_mon,
	uepd_result_if.sink res_mon,
	output int error_count,
	output int pending_count
);

	logic [7:0] ep_size [16];
	logic [1:0] rx_count [16];
	logic bank_tog [32];
	logic data_tog [32];
	logic owned [64];
	result_t expected_results [$];

	assign pending_count = expected_results.size();

	function automatic logic [31:0] control_word(logic [9:0] len, logic tog);
		logic [31:0] w;
		w = '0;
		w[OWN_BIT] = 1'b1;
		w[DTS_BIT] = 1'b1;
		w[DATA01_BIT] = tog;
		w = w | (32'(len) << 16);
		return w;
	endfunction

	function automatic result_t plain_result(logic ok, int slot, logic valid_ep);
		result_t r;
		r = '0;
		r.ok = ok;
		r.data_toggle_now = valid_ep ? data_tog[slot] : 1'b0;
		r.bank_toggle_now = valid_ep ? bank_tog[slot] : 1'b0;
		r.last = 1'b1;
		return r;
	endfunction

	// Applies one command to the shadow endpoint state and queues the results it causes.
	task automatic predict_command(item_t c);
		int ep, rxs, txs, ds, cnt, bank, idx;
		logic [7:0] sz;
		logic [9:0] psz;
		logic tog;
		result_t r;
		ep = c.endpoint;
		rxs = ep * 2;
		txs = ep * 2 + 1;
		ds = ep * 2 + c.direction;
		sz = ep_size[ep];
		cnt = rx_count[ep];
		if (c.opcode == OP_RST_BANK || c.opcode == OP_RST_DATA) begin
			for (int i = 0; i < 32; i++) begin
				if (c.opcode == OP_RST_BANK) bank_tog[i] = 1'b0;
				else data_tog[i] = 1'b0;
			end
			expected_results.push_back(plain_result(1'b1, ds, 1'b1));
			return;
		end
		if (c.opcode > OP_RETURNED) begin
			expected_results.push_back(plain_result(1'b0, ds, 1'b0));
			return;
		end
		case (opcode_t'(c.opcode))
			OP_SIZE: begin
				ep_size[ep] = (c.length_value > 255) ? 8'd255 : c.length_value[7:0];
				expected_results.push_back(plain_result(1'b1, ds, 1'b1));
			end
			OP_RX_PUSH: begin
				if (cnt >= 2) begin
					expected_results.push_back(plain_result(1'b0, rxs, 1'b1));
				end else begin
					bank = (bank_tog[rxs] + cnt) & 1;
					rx_count[ep] = 2'(cnt + 1);
					idx = ep * 4 + bank;
					psz = (c.buffer_given && c.length_value < sz) ? c.length_value : 10'(sz);
					tog = data_tog[rxs];
					data_tog[rxs] = ~tog;
					owned[idx] = 1'b1;
					r = plain_result(1'b1, rxs, 1'b1);
					r.descriptor_write = 1'b1;
					r.descriptor_index = 6'(idx);
					r.descriptor_word = control_word(psz, tog);
					r.address_out = c.buffer_given ? c.buffer_address : '0;
					r.use_default_buffer = ~c.buffer_given;
					r.armed_bytes = psz[7:0];
					expected_results.push_back(r);
				end
			end
			OP_RX_POP: begin
				if (cnt > 0) begin
					bank_tog[rxs] = ~bank_tog[rxs];
					rx_count[ep] = 2'(cnt - 1);
				end
				expected_results.push_back(plain_result(cnt > 0, rxs, 1'b1));
			end
			OP_RX_DEQ, OP_RX_DEQALL: begin
				if (cnt == 0) begin
					expected_results.push_back(plain_result(c.opcode == OP_RX_DEQALL, rxs, 1'b1));
				end else begin
					// Banks are released newest first; dequeue takes only one.
					while (cnt > 0) begin
						cnt--;
						rx_count[ep] = 2'(cnt);
						bank = (bank_tog[rxs] + cnt) & 1;
						idx = ep * 4 + bank;
						owned[idx] = 1'b0;
						r = plain_result(1'b1, rxs, 1'b1);
						r.descriptor_write = 1'b1;
						r.descriptor_index = 6'(idx);
						r.last = (cnt == 0) || (c.opcode == OP_RX_DEQ);
						expected_results.push_back(r);
						if (c.opcode == OP_RX_DEQ) break;
					end
				end
			end
			OP_TX_PUSH: begin
				bank = bank_tog[txs];
				idx = ep * 4 + 2 + bank;
				if (owned[idx]) begin
					expected_results.push_back(plain_result(1'b0, txs, 1'b1));
				end else begin
					psz = (c.length_value < sz) ? c.length_value : 10'(sz);
					tog = data_tog[txs];
					data_tog[txs] = ~tog;
					owned[idx] = 1'b1;
					bank_tog[txs] = ~bank_tog[txs];
					r = plain_result(1'b1, txs, 1'b1);
					r.descriptor_write = 1'b1;
					r.descriptor_index = 6'(idx);
					r.descriptor_word = control_word(psz, tog);
					r.address_out = c.buffer_address;
					r.armed_bytes = psz[7:0];
					expected_results.push_back(r);
				end
			end
			OP_SET_TOG: begin
				data_tog[ds] = c.toggle_value;
				expected_results.push_back(plain_result(1'b1, ds, 1'b1));
			end
			default: begin
				owned[ep * 4 + c.direction * 2 + c.bank_select] = 1'b0;
				expected_results.push_back(plain_result(1'b1, ds, 1'b1));
			end
		endcase
	endtask

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("MISMATCH %s: got %h expected %h", what, got, want);
		error_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t e, g;
		if (!arst_n) begin
			error_count = 0;
			expected_results.delete();
			for (int i = 0; i < 16; i++) begin
				ep_size[i] = '0;
				rx_count[i] = '0;
			end
			for (int i = 0; i < 32; i++) begin
				bank_tog[i] = 1'b0;
				data_tog[i] = 1'b0;
			end
			for (int i = 0; i < 64; i++) owned[i] = 1'b0;
		end else begin
			if (res_mon.valid && res_mon.ready) begin
				g = res_mon.data;
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected result", 32'(g), 32'h0);
				end else begin
					e = expected_results.pop_front();
					if (g.ok !== e.ok) report_mismatch("ok", 32'(g.ok), 32'(e.ok));
					if (g.descriptor_write !== e.descriptor_write)
						report_mismatch("descriptor_write", 32'(g.descriptor_write),
							32'(e.descriptor_write));
					if (g.descriptor_index !== e.descriptor_index)
						report_mismatch("descriptor_index", 32'(g.descriptor_index),
							32'(e.descriptor_index));
					if (g.descriptor_word !== e.descriptor_word)
						report_mismatch("descriptor_word", g.descriptor_word, e.descriptor_word);
					if (g.address_out !== e.address_out)
						report_mismatch("address_out", g.address_out, e.address_out);
					if (g.use_default_buffer !== e.use_default_buffer)
						report_mismatch("use_default_buffer", 32'(g.use_default_buffer),
							32'(e.use_default_buffer));
					if (g.armed_bytes !== e.armed_bytes)
						report_mismatch("armed_bytes", 32'(g.armed_bytes), 32'(e.armed_bytes));
					if (g.data_toggle_now !== e.data_toggle_now)
						report_mismatch("data_toggle_now", 32'(g.data_toggle_now),
							32'(e.data_toggle_now));
					if (g.bank_toggle_now !== e.bank_toggle_now)
						report_mismatch("bank_toggle_now", 32'(g.bank_toggle_now),
							32'(e.bank_toggle_now));
					if (g.last !== e.last) report_mismatch("last", 32'(g.last), 32'(e.last));
				end
			end
			// Prediction after the result pop; a command's results cannot arrive this same edge.
			if (cmd_mon.valid && cmd_mon.ready) predict_command(cmd_mon.data);
		end
	end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps

module tb;
	import uepd_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int error_count;
	int pending_count;
	int idle_cycles = 0;
	// While quiet_mode is set, neither side idles, giving a long stretch of full-rate traffic.
	bit quiet_mode = 1'b0;
	localparam int WATCHDOG_LIMIT = 2000;

	uepd_item_if cmd_ch ();
	uepd_result_if res_ch ();

	usb_endpoint_pingpong_descriptor_manager DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_in(cmd_ch.sink),
		.res_out(res_ch.source)
	);

	descriptor_checker checker_inst (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_mon(cmd_ch.sink),
		.res_mon(res_ch.sink),
		.error_count(error_count),
		.pending_count(pending_count)
	);

	always #1 clk = ~clk;

	initial begin
		cmd_ch.valid = 1'b0;
		cmd_ch.data = '0;
		res_ch.ready = 1'b0;
	end

	// The receiver stalls about 22 percent of the time, except during the quiet stretch.
	always @(negedge clk) begin
		res_ch.ready <= quiet_mode ? 1'b1 : ($urandom_range(99) >= 22);
	end

	// The watchdog counts edges with no transaction on either channel.
	always @(posedge clk) begin
		if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
			idle_cycles <= 0;
		end else if (arst_n) begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Watchdog expired");
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// Drives one command at the falling edge and holds it until accepted.
	// Valid drops only when the sender idles or the stream ends.
	task automatic send_command(item_t c);
		while (!quiet_mode && $urandom_range(99) < 22) begin
			cmd_ch.valid <= 1'b0;
			@(negedge clk);
		end
		cmd_ch.data <= c;
		cmd_ch.valid <= 1'b1;
		do @(posedge clk); while (!cmd_ch.ready);
		@(negedge clk);
	endtask

	function automatic item_t make_command(logic [3:0] op, logic [3:0] ep);
		item_t c;
		c.opcode = op;
		c.endpoint = ep;
		c.direction = 1'($urandom_range(1));
		c.bank_select = 1'($urandom_range(1));
		c.toggle_value = 1'($urandom_range(1));
		c.length_value = 10'($urandom_range(1023));
		c.buffer_address = $urandom;
		c.buffer_given = 1'($urandom_range(1));
		return c;
	endfunction

	task automatic wait_drained();
		cmd_ch.valid <= 1'b0;
		while (pending_count != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	initial begin
		item_t c;
		int pick;
		logic [3:0] ep;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: size extremes, saturation, full and empty queues, busy transmit bank.
		c = make_command(OP_SIZE, 4'd0); c.length_value = 10'd1023; send_command(c);
		c = make_command(OP_SIZE, 4'd15); c.length_value = 10'd0; send_command(c);
		c = make_command(OP_SIZE, 4'd1); c.length_value = 10'd64; send_command(c);
		c = make_command(OP_RX_POP, 4'd1); send_command(c);
		c = make_command(OP_RX_DEQ, 4'd1); send_command(c);
		c = make_command(OP_RX_DEQALL, 4'd1); send_command(c);
		for (int i = 0; i < 3; i++) begin
			c = make_command(OP_RX_PUSH, 4'd1); c.buffer_given = i[0]; send_command(c);
		end
		c = make_command(OP_RX_DEQALL, 4'd1); send_command(c);
		c = make_command(OP_RX_PUSH, 4'd0); c.length_value = 10'd1023;
		c.buffer_given = 1'b1; c.buffer_address = '1; send_command(c);
		c = make_command(OP_RX_PUSH, 4'd0); c.length_value = 10'd0; send_command(c);
		c = make_command(OP_RX_DEQ, 4'd0); send_command(c);
		c = make_command(OP_RX_POP, 4'd0); send_command(c);
		c = make_command(OP_TX_PUSH, 4'd1); send_command(c);
		c = make_command(OP_TX_PUSH, 4'd1); send_command(c);
		c = make_command(OP_TX_PUSH, 4'd1); send_command(c);
		c = make_command(OP_RETURNED, 4'd1); c.direction = 1'b1; c.bank_select = 1'b0;
		send_command(c);
		c = make_command(OP_SET_TOG, 4'd15); c.toggle_value = 1'b1; send_command(c);
		c = make_command(OP_RST_BANK, 4'd3); send_command(c);
		c = make_command(OP_RST_DATA, 4'd3); send_command(c);
		c = make_command(4'd10, 4'd2); send_command(c);
		c = make_command(4'd15, 4'd2); send_command(c);

		// Pause until the block has delivered every result.
		wait_drained();

		// Random: mostly arming and releasing on a few endpoints so queues fill and drain.
		for (int n = 0; n < 1500; n++) begin
			quiet_mode = (n >= 600 && n < 800);
			pick = $urandom_range(99);
			ep = ($urandom_range(3) == 0) ? 4'($urandom) : 4'($urandom_range(3));
			if (pick < 8) c = make_command(OP_SIZE, ep);
			else if (pick < 30) c = make_command(OP_RX_PUSH, ep);
			else if (pick < 42) c = make_command(OP_RX_POP, ep);
			else if (pick < 48) c = make_command(OP_RX_DEQ, ep);
			else if (pick < 56) c = make_command(OP_RX_DEQALL, ep);
			else if (pick < 74) c = make_command(OP_TX_PUSH, ep);
			else if (pick < 80) c = make_command(OP_SET_TOG, ep);
			else if (pick < 82) c = make_command(OP_RST_BANK, ep);
			else if (pick < 84) c = make_command(OP_RST_DATA, ep);
			else if (pick < 97) c = make_command(OP_RETURNED, ep);
			else c = make_command(4'($urandom_range(15, 10)), ep);
			if (c.opcode == OP_SIZE && $urandom_range(3) == 0)
				c.length_value = 10'($urandom_range(255));
			send_command(c);
		end
		quiet_mode = 1'b0;

		wait_drained();
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
